@@ rtl/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned TERM_W   = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned IDX_W    = 11;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 32;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] CELL_ATTR  = 8'h07;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_BKSP  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

endpackage

`default_nettype wire

@@ rtl/text_console_writer.sv @@
// Multi-terminal text console: screen memory, cursor registers and request sequencer.
// Sequence: put, backspace and newline give their result from DONE after EXEC; a read
// passes through RDWAIT as well; scroll and clear add a SWEEP over one screen of cells.
// One item at a time: the next is accepted only once the last has left DONE.
// Reset: cursors go home, then a pass writes spaces to all TERMINALS*ROWS*COLUMNS
// cells (8000 by default) before the first item is accepted.
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int unsigned TERMINALS = 4,
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // terminal [1:0], char_code [9:2], cell_index [20:10], zero [23:21]
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,
  // req_type [1:0]
  input  wire logic [REQ_W-1:0]    s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // cursor_position [10:0], read_char [18:11], read_attribute [26:19], zero [31:27]
  output logic [M_DATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned CELLS  = ROWS * COLUMNS;
  localparam int unsigned TOTAL  = TERMINALS * CELLS;
  localparam int unsigned AW     = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int unsigned PW     = $clog2(CELLS);
  localparam int unsigned CW     = $clog2(COLUMNS);
  localparam int unsigned RW     = $clog2(ROWS);
  localparam int unsigned TIX_W  = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

  localparam logic [AW-1:0] CELLS_A   = AW'(CELLS);
  localparam logic [AW-1:0] COLUMNS_A = AW'(COLUMNS);
  localparam logic [AW-1:0] TOTAL_M1  = AW'(TOTAL - 1);
  localparam logic [PW-1:0] COLUMNS_P = PW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_SWEEP,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [CHAR_W-1:0] mem [TOTAL];
  logic [CHAR_W-1:0] rdata_q;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  logic [CW-1:0] col_q [TERMINALS];
  logic [RW-1:0] row_q [TERMINALS];

  req_e              req_q;
  logic [TERM_W-1:0] term_q;
  logic [CHAR_W-1:0] char_q;
  logic [IDX_W-1:0]  idx_q;

  logic [AW-1:0]     ptr_q, end_q, copy_lim_q;
  logic              wr_pend_q, wr_use_rd_q;
  logic [AW-1:0]     wr_addr_q;
  logic [CHAR_W-1:0] wr_data_q;

  logic [POS_W-1:0]  res_pos_q;
  logic [CHAR_W-1:0] res_char_q, res_attr_q;
  logic              m_valid_q;
  logic [M_DATA_W-1:0] m_data_q;

  // Request decode for the item in EXEC.
  logic [TIX_W-1:0] tix;
  logic             t_ok, is_nl, rd_ok, scroll;
  logic [CW-1:0]    col_c, col_n;
  logic [RW-1:0]    row_c, row_n;
  logic [AW-1:0]    base, old_addr, new_addr;
  logic [PW-1:0]    old_pos, new_pos;
  logic             do_write;
  logic [CHAR_W-1:0] write_char;
  logic             sweep_copy, sweep_last;

  always_comb begin
    tix    = TIX_W'(term_q);
    t_ok   = 32'(term_q) < TERMINALS;
    col_c  = col_q[tix];
    row_c  = row_q[tix];
    base   = AW'(AW'(tix) * CELLS_A);
    is_nl  = (char_q == CHAR_LF) || (char_q == CHAR_CR);
    rd_ok  = 32'(idx_q) < CELLS;
    col_n  = col_c;
    row_n  = row_c;
    scroll = 1'b0;
    do_write   = 1'b0;
    write_char = BLANK_CHAR;
    unique case (req_q)
      REQ_PUT: begin
        if (is_nl || col_c == COL_LAST) begin
          col_n = '0;
          if (row_c == ROW_LAST) begin
            scroll = 1'b1;
          end else begin
            row_n = row_c + 1'b1;
          end
        end else begin
          col_n = col_c + 1'b1;
        end
        do_write   = !is_nl;
        write_char = char_q;
      end
      REQ_BKSP: begin
        if (col_c == '0) begin
          if (row_c != '0) begin
            row_n = row_c - 1'b1;
            col_n = COL_LAST;
          end
        end else begin
          col_n = col_c - 1'b1;
        end
        do_write = 1'b1;
      end
      REQ_CLEAR: begin
        col_n = '0;
        row_n = '0;
      end
      default: ;
    endcase
    old_pos  = PW'(PW'(row_c) * COLUMNS_P + PW'(col_c));
    new_pos  = PW'(PW'(row_n) * COLUMNS_P + PW'(col_n));
    old_addr = base + AW'(old_pos);
    new_addr = base + AW'(new_pos);
  end

  assign sweep_copy = ptr_q < copy_lim_q;
  assign sweep_last = ptr_q == end_q;

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = ptr_q + COLUMNS_A;
    if (state_q == ST_SWEEP) begin
      mem_re = sweep_copy;
    end else if (state_q == ST_EXEC) begin
      mem_re    = t_ok && req_q == REQ_READ && rd_ok;
      mem_raddr = base + AW'(idx_q);
    end
  end

  // Screen memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      mem[wr_addr_q] <= wr_use_rd_q ? rdata_q : wr_data_q;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !wr_pend_q;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      ptr_q      <= '0;
      end_q      <= TOTAL_M1;
      copy_lim_q <= '0;
      wr_pend_q  <= 1'b0;
      m_valid_q  <= 1'b0;
      for (int i = 0; i < TERMINALS; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
      end
    end else begin
      wr_pend_q <= 1'b0;
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q) inside
        ST_INIT, ST_SWEEP: begin
          wr_pend_q   <= 1'b1;
          wr_addr_q   <= ptr_q;
          wr_use_rd_q <= sweep_copy;
          wr_data_q   <= BLANK_CHAR;
          ptr_q       <= ptr_q + 1'b1;
          if (sweep_last) begin
            state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            req_q   <= req_e'(s_axis_tuser);
            term_q  <= s_axis_tdata[1:0];
            char_q  <= s_axis_tdata[9:2];
            idx_q   <= s_axis_tdata[20:10];
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_pos_q  <= '0;
          res_char_q <= '0;
          res_attr_q <= '0;
          state_q    <= ST_DONE;
          if (t_ok) begin
            res_pos_q <= POS_W'(new_pos);
            if (req_q == REQ_READ) begin
              res_char_q <= BLANK_CHAR;
              res_attr_q <= CELL_ATTR;
              if (rd_ok) begin
                state_q <= ST_RDWAIT;
              end
            end else begin
              col_q[tix] <= col_n;
              row_q[tix] <= row_n;
              if (do_write) begin
                wr_pend_q   <= 1'b1;
                wr_use_rd_q <= 1'b0;
                wr_data_q   <= write_char;
                wr_addr_q   <= (req_q == REQ_BKSP) ? new_addr : old_addr;
              end
              if (scroll || req_q == REQ_CLEAR) begin
                ptr_q      <= base;
                end_q      <= base + CELLS_A - 1'b1;
                copy_lim_q <= (req_q == REQ_CLEAR) ? base : base + CELLS_A - COLUMNS_A;
                state_q    <= ST_SWEEP;
              end
            end
          end
        end
        ST_RDWAIT: begin
          res_char_q <= rdata_q;
          state_q    <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= M_DATA_W'({res_attr_q, res_char_q, res_pos_q});
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Earlier writes have landed before a new item touches the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> !wr_pend_q)
    else $error("write pending at request start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC && t_ok |-> 32'(col_c) < COLUMNS && 32'(row_c) < ROWS)
    else $error("cursor out of screen");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> 32'(wr_addr_q) < TOTAL)
    else $error("screen write out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RDWAIT |-> $past(state_q) == ST_EXEC && $past(mem_re))
    else $error("read wait without memory read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SWEEP && sweep_copy |-> 32'(mem_raddr) < TOTAL)
    else $error("scroll source out of range");

endmodule

`default_nettype wire
